// ===== design/mntr_pkg.sv =====
// ----------------------------------------------------------------------------
// mntr_pkg
// Shared types and constants for the mesh neighbour table router.
// ----------------------------------------------------------------------------
package mntr_pkg;

  localparam int unsigned PEER_SLOTS_DEF = 16;

  localparam logic [31:0] TIMEOUT_RST  = 32'd60000;
  localparam logic [7:0]  MAX_HOPS_RST = 8'd5;
  localparam logic [7:0]  MAX_PLEN_RST = 8'd200;

  localparam logic signed [7:0] GW_RSSI_FLOOR = -8'sd127;
  localparam logic [47:0]       BCAST_MAC     = '1;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_TX    = 2'd1,
    OP_CLEAN = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_OWN_ID   = 3'd0,
    CFG_IS_GW    = 3'd1,
    CFG_TIMEOUT  = 3'd2,
    CFG_MAX_HOPS = 3'd3,
    CFG_MAX_PLEN = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOCAL   = 4'd0,
    ST_BCAST   = 4'd1,
    ST_DIRECT  = 4'd2,
    ST_GW      = 4'd3,
    ST_NOROUTE = 4'd4,
    ST_HOPLIM  = 4'd5,
    ST_NOTOURS = 4'd6,
    ST_TOOBIG  = 4'd7,
    ST_CLEANED = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_UPDATE,
    FSM_ROUTE,
    FSM_SWEEP,
    FSM_RESULT
  } fsm_e;

  typedef struct packed {
    logic [47:0]       mac;
    logic [31:0]       node;
    logic signed [7:0] strength;
    logic [31:0]       seen_ms;
    logic              gw;
  } entry_t;

  typedef struct packed {
    logic [31:0] own_id;
    logic        is_gw;
    logic [31:0] timeout;
    logic [7:0]  max_hops;
    logic [7:0]  max_plen;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       now_ms;
    logic [47:0]       src_mac;
    logic [31:0]       src_node;
    logic signed [7:0] rssi;
    logic              sender_is_gateway;
    logic [31:0]       dst_node;
    logic              target_is_broadcast;
    logic [7:0]        hops_in;
    logic [7:0]        data_len;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [47:0] next_hop_mac;
    logic [7:0]  hop_out;
    logic [15:0] sequence_res;
    logic [4:0]  peer_count;
    logic [4:0]  removed_count;
    logic        peer_is_new;
    logic        table_full;
  } result_t;

endpackage

// ===== design/mntr_if.sv =====
// ----------------------------------------------------------------------------
// mntr_in_if / mntr_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface mntr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [31:0]       now_ms;
  logic [47:0]       src_mac;
  logic [31:0]       src_node;
  logic signed [7:0] rssi;
  logic              sender_is_gateway;
  logic [31:0]       dst_node;
  logic              target_is_broadcast;
  logic [7:0]        hops_in;
  logic [7:0]        data_len;

  modport source (output valid, op, now_ms, src_mac, src_node, rssi, sender_is_gateway,
                  dst_node, target_is_broadcast, hops_in, data_len, input ready);
  modport sink (input valid, op, now_ms, src_mac, src_node, rssi, sender_is_gateway,
                dst_node, target_is_broadcast, hops_in, data_len, output ready);
endinterface

interface mntr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [47:0] next_hop_mac;
  logic [7:0]  hop_out;
  logic [15:0] sequence_res;
  logic [4:0]  peer_count;
  logic [4:0]  removed_count;
  logic        peer_is_new;
  logic        table_full;

  modport source (output valid, status, next_hop_mac, hop_out, sequence_res, peer_count,
                  removed_count, peer_is_new, table_full, input ready);
  modport sink (input valid, status, next_hop_mac, hop_out, sequence_res, peer_count,
                removed_count, peer_is_new, table_full, output ready);
endinterface

// ===== design/mntr_mem.sv =====
// ----------------------------------------------------------------------------
// mntr_mem
// Peer table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mntr_mem #(
  parameter int unsigned Slots = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  mntr_pkg::entry_t      wdata_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output mntr_pkg::entry_t      rdata_o
);
  import mntr_pkg::*;

  entry_t mem [Slots];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mntr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mntr_ctrl
// Sequencer: scans the peer table, updates, compacts and routes.
// ----------------------------------------------------------------------------
module mntr_ctrl #(
  parameter int unsigned PeerSlots = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mntr_pkg::cfg_t cfg_i,
  mntr_in_if.sink        in_if,
  mntr_out_if.source     out_if
);
  import mntr_pkg::*;

  localparam int unsigned IdxW = (PeerSlots > 1) ? $clog2(PeerSlots) : 1;
  localparam int unsigned CntW = $clog2(PeerSlots + 1);

  fsm_e            state_q, state_d;
  item_t           itm_q;
  result_t         res_q, out_q;
  logic            out_valid_q;
  logic [15:0]     seq_q;
  logic [CntW-1:0] cnt_q, addr_q, wp_q;
  logic            rv_q;
  logic [IdxW-1:0] ridx_q, fidx_q;
  logic            found_q, dfound_q, bfound_q;
  entry_t          fent_q;
  logic [47:0]     dmac_q, bmac_q;
  logic signed [7:0] brssi_q;
  logic [7:0]      rhop_q;

  entry_t          rdata;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;

  logic            in_acc, scan_done, rd_en, keep, res_go, local_hit, room;
  logic [8:0]      h1;
  entry_t          new_ent, upd_ent;
  result_t         res_init, res_fin;

  mntr_mem #(.Slots(PeerSlots), .IdxW(IdxW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign in_if.ready = (state_q == FSM_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign scan_done   = (addr_q == cnt_q) && !rv_q;
  assign res_go      = !out_valid_q || out_if.ready;
  assign local_hit   = itm_q.target_is_broadcast || (itm_q.dst_node == cfg_i.own_id);
  assign h1          = {1'b0, itm_q.hops_in} + 9'd1;
  assign room        = cnt_q < CntW'(PeerSlots);
  assign keep        = !((itm_q.now_ms - rdata.seen_ms) > cfg_i.timeout);

  always_comb begin
    new_ent = '{mac: itm_q.src_mac, node: itm_q.src_node, strength: itm_q.rssi,
                seen_ms: itm_q.now_ms, gw: itm_q.sender_is_gateway};
    upd_ent = fent_q;
    upd_ent.strength = itm_q.rssi;
    upd_ent.seen_ms  = itm_q.now_ms;
    // initial result of an accepted item; sends that skip the scan are final here
    res_init = '{status: ST_NOTOURS, default: '0};
    if (op_e'(in_if.op) == OP_TX) begin
      if (in_if.data_len > cfg_i.max_plen) begin
        res_init.status = ST_TOOBIG;
      end else begin
        res_init.sequence_res = seq_q;
        if (in_if.target_is_broadcast) begin
          res_init.status       = ST_BCAST;
          res_init.next_hop_mac = BCAST_MAC;
        end
      end
    end
    res_fin = res_q;
    res_fin.peer_count = 5'(cnt_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(in_if.op))
            OP_RX:    state_d = FSM_LOOKUP;
            OP_TX: begin
              if (in_if.data_len > cfg_i.max_plen || in_if.target_is_broadcast) begin
                state_d = FSM_RESULT;
              end else begin
                state_d = FSM_ROUTE;
              end
            end
            OP_CLEAN: state_d = FSM_SWEEP;
            default:  state_d = FSM_RESULT;
          endcase
        end
      end
      FSM_LOOKUP: if (scan_done) state_d = FSM_UPDATE;
      FSM_UPDATE: begin
        if (local_hit || !cfg_i.is_gw || !(h1 < {1'b0, cfg_i.max_hops})) begin
          state_d = FSM_RESULT;
        end else begin
          state_d = FSM_ROUTE;
        end
      end
      FSM_ROUTE:  if (scan_done) state_d = FSM_RESULT;
      FSM_SWEEP:  if (scan_done) state_d = FSM_RESULT;
      FSM_RESULT: if (res_go) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp_q[IdxW-1:0];
    mem_wdata = rdata;
    unique case (state_q)
      FSM_LOOKUP, FSM_ROUTE: rd_en = addr_q < cnt_q;
      FSM_SWEEP: begin
        rd_en  = addr_q < cnt_q;
        mem_we = rv_q && keep;
      end
      FSM_UPDATE: begin
        mem_we    = found_q || room;
        mem_waddr = found_q ? fidx_q : cnt_q[IdxW-1:0];
        mem_wdata = found_q ? upd_ent : new_ent;
      end
      default: ;
    endcase
    mem_re = rd_en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      wp_q        <= '0;
      rv_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FSM_RESULT && res_go) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      // no read is issued while idle or updating, so this also clears it there
      rv_q <= rd_en;
      if (rd_en) addr_q <= addr_q + CntW'(1);
      if (in_acc) begin
        addr_q <= '0;
        wp_q   <= '0;
        if (op_e'(in_if.op) == OP_TX && !(in_if.data_len > cfg_i.max_plen)) begin
          seq_q <= seq_q + 16'd1;
        end
      end
      if (state_q == FSM_UPDATE) begin
        addr_q <= '0;
        if (!found_q && room) cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == FSM_SWEEP) begin
        if (rv_q && keep) wp_q <= wp_q + CntW'(1);
        if (scan_done) cnt_q <= wp_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == FSM_RESULT && res_go) begin
      out_q <= res_fin;
    end
    ridx_q <= addr_q[IdxW-1:0];
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          itm_q    <= '{op: in_if.op, now_ms: in_if.now_ms, src_mac: in_if.src_mac,
                        src_node: in_if.src_node, rssi: in_if.rssi,
                        sender_is_gateway: in_if.sender_is_gateway,
                        dst_node: in_if.dst_node,
                        target_is_broadcast: in_if.target_is_broadcast,
                        hops_in: in_if.hops_in, data_len: in_if.data_len};
          res_q    <= res_init;
          found_q  <= 1'b0;
          dfound_q <= 1'b0;
          bfound_q <= 1'b0;
          brssi_q  <= GW_RSSI_FLOOR;
          rhop_q   <= '0;
        end
      end
      FSM_LOOKUP: begin
        if (rv_q && !found_q && rdata.mac == itm_q.src_mac) begin
          found_q <= 1'b1;
          fidx_q  <= ridx_q;
          fent_q  <= rdata;
        end
      end
      FSM_UPDATE: begin
        res_q.peer_is_new <= !found_q && room;
        res_q.table_full  <= !found_q && !room;
        rhop_q            <= h1[7:0];
        priority if (local_hit) begin
          res_q.status  <= ST_LOCAL;
          res_q.hop_out <= itm_q.hops_in;
        end else if (!cfg_i.is_gw) begin
          res_q.status  <= ST_NOTOURS;
          res_q.hop_out <= itm_q.hops_in;
        end else begin
          res_q.status  <= ST_HOPLIM;
          res_q.hop_out <= h1[7:0];
        end
      end
      FSM_ROUTE: begin
        if (rv_q) begin
          if (!dfound_q && rdata.node == itm_q.dst_node) begin
            dfound_q <= 1'b1;
            dmac_q   <= rdata.mac;
          end
          if (rdata.gw && rdata.strength > brssi_q) begin
            bfound_q <= 1'b1;
            brssi_q  <= rdata.strength;
            bmac_q   <= rdata.mac;
          end
        end
        if (scan_done) begin
          priority if (dfound_q) begin
            res_q.status       <= ST_DIRECT;
            res_q.next_hop_mac <= dmac_q;
            res_q.hop_out      <= rhop_q;
          end else if (bfound_q) begin
            res_q.status       <= ST_GW;
            res_q.next_hop_mac <= bmac_q;
            res_q.hop_out      <= rhop_q + 8'd1;
          end else begin
            res_q.status       <= ST_NOROUTE;
            res_q.next_hop_mac <= '0;
            res_q.hop_out      <= rhop_q;
          end
        end
      end
      FSM_SWEEP: begin
        if (scan_done) begin
          res_q.status        <= ST_CLEANED;
          res_q.removed_count <= 5'(cnt_q - wp_q);
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = out_q.status;
  assign out_if.next_hop_mac  = out_q.next_hop_mac;
  assign out_if.hop_out       = out_q.hop_out;
  assign out_if.sequence_res  = out_q.sequence_res;
  assign out_if.peer_count    = out_q.peer_count;
  assign out_if.removed_count = out_q.removed_count;
  assign out_if.peer_is_new   = out_q.peer_is_new;
  assign out_if.table_full    = out_q.table_full;

endmodule

// ===== design/mesh_neighbor_table_router.sv =====
// ----------------------------------------------------------------------------
// mesh_neighbor_table_router
// Neighbour table and frame router for a mesh node.
// ----------------------------------------------------------------------------
// One item at a time. The peer table sits in a single-port-write, registered-
// read RAM kept packed in insertion order, with the fill count as valid state.
// A receive scans the table once for the source address, writes the refresh
// or append, and when forwarding scans again for routing. A send scans once,
// a broadcast or refused send skips the scan. A cleanup streams every entry
// through the read port and writes survivors back at a trailing pointer,
// compacting in place. Each item also passes the accept and the result state.
// The table read port sets the pace. A finished result waits in an output
// register; the next item is taken meanwhile. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module mesh_neighbor_table_router #(
  parameter int unsigned PEER_SLOTS = mntr_pkg::PEER_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  mntr_in_if.sink     in_if,
  mntr_out_if.source  out_if
);
  import mntr_pkg::*;

  cfg_t cfg_q;

  // config registers, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_id: '0, is_gw: 1'b0, timeout: TIMEOUT_RST,
                 max_hops: MAX_HOPS_RST, max_plen: MAX_PLEN_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_ID:   cfg_q.own_id   <= cfg_wdata_i;
        CFG_IS_GW:    cfg_q.is_gw    <= cfg_wdata_i[0];
        CFG_TIMEOUT:  cfg_q.timeout  <= cfg_wdata_i;
        CFG_MAX_HOPS: cfg_q.max_hops <= cfg_wdata_i[7:0];
        CFG_MAX_PLEN: cfg_q.max_plen <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  mntr_ctrl #(.PeerSlots(PEER_SLOTS)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // an accepted item keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input open right after accept");

  // a refused send never consumes a sequence number
  a_toobig_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status == ST_TOOBIG) |-> (out_if.sequence_res == 16'd0))
    else $error("refused send carries a sequence number");

  // insert and overflow flags are exclusive
  a_new_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.peer_is_new && out_if.table_full))
    else $error("peer_is_new and table_full both set");

endmodule

// ===== dv/mntr_tb_if.sv =====
// ----------------------------------------------------------------------------
// mntr_tb_if
// The channel interfaces are part of the design sources; this file only holds
// the address pool size shared by the testbench top.
// ----------------------------------------------------------------------------
package mntr_tb_pkg;
  import mntr_pkg::*;

  // Pool of radio addresses so that refreshes and direct routes happen often.
  localparam int unsigned MAC_POOL = 24;
endpackage

// ===== dv/mntr_route_checker.sv =====
// ----------------------------------------------------------------------------
// mntr_route_checker
// Watches the request and result channels, keeps a shadow neighbour table and
// compares every result item against the predicted one.
// ----------------------------------------------------------------------------
module mntr_route_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  mntr_in_if.sink     req,
  mntr_out_if.sink    rsp,
  output int          fail_cnt_o,
  output int          pending_o
);
  import mntr_pkg::*;

  localparam int unsigned SLOTS = PEER_SLOTS_DEF;

  cfg_t              cfg;
  logic [SLOTS-1:0]  tbl_valid;
  entry_t            tbl [SLOTS];
  logic [15:0]       seq_ctr;
  result_t           expected_q [$];

  function automatic logic [4:0] count_peers();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) n++;
    return 5'(n);
  endfunction

  // Routing decision for a frame; hop is the count before routing.
  task automatic route(input logic [31:0] target, input logic bcast, input logic [8:0] hop,
                       inout result_t r);
    int best;
    logic signed [7:0] top_rssi;
    best = -1;
    top_rssi = GW_RSSI_FLOOR;
    r.hop_out = hop[7:0];
    r.next_hop_mac = '0;
    if (bcast) begin
      r.status = ST_BCAST;
      r.next_hop_mac = BCAST_MAC;
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl[i].node == target) begin
        r.status = ST_DIRECT;
        r.next_hop_mac = tbl[i].mac;
        return;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl[i].gw && tbl[i].strength > top_rssi) begin
        top_rssi = tbl[i].strength;
        best = i;
      end
    end
    if (best >= 0) begin
      r.status = ST_GW;
      r.next_hop_mac = tbl[best].mac;
      r.hop_out = 8'(hop + 9'd1);
    end else begin
      r.status = ST_NOROUTE;
    end
  endtask

  task automatic predict_route_result(input item_t it);
    result_t r;
    logic found;
    logic [8:0] h1;
    int n, k;
    r = '0;
    r.status = ST_NOTOURS;
    case (op_e'(it.op))
      OP_RX: begin
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && tbl_valid[i] && tbl[i].mac == it.src_mac) begin
            tbl[i].strength = it.rssi;
            tbl[i].seen_ms  = it.now_ms;
            found = 1'b1;
          end
        end
        if (!found) begin
          n = count_peers();
          if (n < SLOTS) begin
            tbl_valid[n] = 1'b1;
            tbl[n] = '{mac: it.src_mac, node: it.src_node, strength: it.rssi,
                       seen_ms: it.now_ms, gw: it.sender_is_gateway};
            r.peer_is_new = 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
        if (it.target_is_broadcast || it.dst_node == cfg.own_id) begin
          r.status = ST_LOCAL;
          r.hop_out = it.hops_in;
        end else if (cfg.is_gw) begin
          h1 = {1'b0, it.hops_in} + 9'd1;
          if (h1 < {1'b0, cfg.max_hops}) begin
            route(it.dst_node, 1'b0, h1, r);
          end else begin
            r.status = ST_HOPLIM;
            r.hop_out = h1[7:0];
          end
        end else begin
          r.hop_out = it.hops_in;
        end
      end
      OP_TX: begin
        if (it.data_len > cfg.max_plen) begin
          r.status = ST_TOOBIG;
        end else begin
          r.sequence_res = seq_ctr;
          seq_ctr++;
          route(it.dst_node, it.target_is_broadcast, 9'd0, r);
        end
      end
      OP_CLEAN: begin
        k = 0;
        while (k < SLOTS) begin
          if (tbl_valid[k] && (it.now_ms - tbl[k].seen_ms) > cfg.timeout) begin
            for (int j = k; j + 1 < SLOTS; j++) begin
              tbl_valid[j] = tbl_valid[j+1];
              tbl[j] = tbl[j+1];
            end
            tbl_valid[SLOTS-1] = 1'b0;
            r.removed_count++;
          end else begin
            k++;
          end
        end
        r.status = ST_CLEANED;
      end
      default: ;
    endcase
    r.peer_count = count_peers();
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic compare_field(input string name, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    result_t e;
    if (!rst_ni) begin
      cfg <= '{own_id: '0, is_gw: 1'b0, timeout: TIMEOUT_RST, max_hops: MAX_HOPS_RST,
               max_plen: MAX_PLEN_RST};
      tbl_valid = '0;
      seq_ctr = '0;
      expected_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_OWN_ID:   cfg.own_id   <= cfg_wdata_i;
          CFG_IS_GW:    cfg.is_gw    <= cfg_wdata_i[0];
          CFG_TIMEOUT:  cfg.timeout  <= cfg_wdata_i;
          CFG_MAX_HOPS: cfg.max_hops <= cfg_wdata_i[7:0];
          CFG_MAX_PLEN: cfg.max_plen <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        it = '{op: req.op, now_ms: req.now_ms, src_mac: req.src_mac,
               src_node: req.src_node, rssi: req.rssi,
               sender_is_gateway: req.sender_is_gateway, dst_node: req.dst_node,
               target_is_broadcast: req.target_is_broadcast, hops_in: req.hops_in,
               data_len: req.data_len};
        predict_route_result(it);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_cnt_o++;
        end else begin
          e = expected_q.pop_front();
          compare_field("status", 48'(e.status), 48'(rsp.status));
          compare_field("next_hop_mac", e.next_hop_mac, rsp.next_hop_mac);
          compare_field("hop_out", 48'(e.hop_out), 48'(rsp.hop_out));
          compare_field("sequence_res", 48'(e.sequence_res), 48'(rsp.sequence_res));
          compare_field("peer_count", 48'(e.peer_count), 48'(rsp.peer_count));
          compare_field("removed_count", 48'(e.removed_count), 48'(rsp.removed_count));
          compare_field("peer_is_new", 48'(e.peer_is_new), 48'(rsp.peer_is_new));
          compare_field("table_full", 48'(e.table_full), 48'(rsp.table_full));
        end
      end
    end
  end

  assign pending_o = expected_q.size();
endmodule

// ===== dv/mesh_neighbor_table_router_tb.sv =====
// ----------------------------------------------------------------------------
// mesh_neighbor_table_router_tb
// Drives request items and register writes into the router, with random
// stalls on both channels, and leaves checking to mntr_route_checker.
// ----------------------------------------------------------------------------
module mesh_neighbor_table_router_tb;
  import mntr_pkg::*;
  import mntr_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  int          fail_cnt;
  int          pending;
  int          idle_cycles = 0;
  bit          calm;        // no idling in the closing stretch
  bit          rsp_stalls;

  // Time base and addresses kept small so peers time out and repeat.
  logic [31:0] clock_ms;
  logic [47:0] mac_pool  [MAC_POOL];
  logic [31:0] node_pool [MAC_POOL];

  mntr_in_if  req_if ();
  mntr_out_if rsp_if ();

  mesh_neighbor_table_router u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (req_if.sink),
    .out_if      (rsp_if.source)
  );

  mntr_route_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if.sink),
    .rsp         (rsp_if.sink),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: cycles without any accepted item on either channel or register write.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: ready drops in random bursts unless stalls are off or in the calm stretch.
  initial begin
    int n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rsp_stalls && !calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        rsp_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait for all expectations, then the worst-case busy time of the block.
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_item(input item_t it);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      req_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    req_if.valid               <= 1'b1;
    req_if.op                  <= it.op;
    req_if.now_ms              <= it.now_ms;
    req_if.src_mac             <= it.src_mac;
    req_if.src_node            <= it.src_node;
    req_if.rssi                <= it.rssi;
    req_if.sender_is_gateway   <= it.sender_is_gateway;
    req_if.dst_node            <= it.dst_node;
    req_if.target_is_broadcast <= it.target_is_broadcast;
    req_if.hops_in             <= it.hops_in;
    req_if.data_len            <= it.data_len;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    req_if.valid <= 1'b0;
  endtask

  // Random item: mostly pool addresses and nearby times, some raw noise.
  function automatic item_t rand_item(input logic [31:0] own);
    item_t it;
    int p, q;
    p = $urandom_range(0, MAC_POOL - 1);
    q = $urandom_range(0, MAC_POOL - 1);
    it.op = $urandom_range(0, 9) < 5 ? OP_RX : ($urandom_range(0, 9) < 7 ? OP_TX :
            ($urandom_range(0, 19) == 0 ? OP_NONE : OP_CLEAN));
    clock_ms += $urandom_range(0, 400);
    it.now_ms = $urandom_range(0, 49) == 0 ? $urandom() : clock_ms;
    it.src_mac = $urandom_range(0, 19) == 0 ? 48'({$urandom(), $urandom()}) : mac_pool[p];
    it.src_node = $urandom_range(0, 19) == 0 ? $urandom() : node_pool[p];
    it.rssi = 8'($urandom());
    it.sender_is_gateway = $urandom_range(0, 2) == 0;
    case ($urandom_range(0, 5))
      0:       it.dst_node = own;
      1:       it.dst_node = $urandom();
      default: it.dst_node = node_pool[q];
    endcase
    it.target_is_broadcast = $urandom_range(0, 5) == 0;
    it.hops_in = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 6));
    it.data_len = 8'($urandom());
    return it;
  endfunction

  initial begin
    item_t it;
    logic [31:0] own;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OWN_ID;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_RX;
    req_if.now_ms = '0;
    req_if.src_mac = '0;
    req_if.src_node = '0;
    req_if.rssi = '0;
    req_if.sender_is_gateway = 1'b0;
    req_if.dst_node = '0;
    req_if.target_is_broadcast = 1'b0;
    req_if.hops_in = '0;
    req_if.data_len = '0;
    calm = 1'b0;
    rsp_stalls = 1'b1;
    clock_ms = 32'd1000;
    for (int i = 0; i < MAC_POOL; i++) begin
      mac_pool[i]  = 48'({$urandom(), $urandom()});
      node_pool[i] = $urandom();
    end
    mac_pool[0] = '1;
    mac_pool[1] = '0;
    node_pool[0] = '1;
    node_pool[1] = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: gateway node with a tight hop limit and a full table.
    own = 32'h0000_0042;
    write_reg(CFG_OWN_ID, own);
    write_reg(CFG_IS_GW, 32'd1);
    write_reg(CFG_MAX_HOPS, 32'd3);
    write_reg(CFG_MAX_PLEN, 32'd255);
    write_reg(CFG_TIMEOUT, 32'd500);
    it = '0;
    it.dst_node = 32'hdead_beef;
    it.op = OP_TX;                                   // no peers: no route
    send_item(it);
    for (int i = 0; i < 17; i++) begin               // fill up, then overflow
      it.op = OP_RX;
      it.now_ms = 32'd100 + 32'(i);
      it.src_mac = mac_pool[i];
      it.src_node = node_pool[i];
      it.rssi = (i == 2) ? -8'sd127 : (i == 3) ? 8'sd127 : (i == 4) ? 8'sd127 : -8'sd128;
      it.sender_is_gateway = (i >= 2 && i <= 5);
      it.dst_node = (i == 6) ? own : 32'h1234_5678;
      it.target_is_broadcast = (i == 7);
      it.hops_in = (i == 8) ? 8'hff : (i == 9) ? 8'd2 : 8'd1;
      send_item(it);
    end
    it.op = OP_TX;                                   // via strongest gateway
    it.target_is_broadcast = 1'b0;
    send_item(it);
    it.dst_node = node_pool[5];                      // direct
    send_item(it);
    it.target_is_broadcast = 1'b1;                   // broadcast
    send_item(it);
    it.op = OP_NONE;
    send_item(it);
    it.op = OP_CLEAN;                                // removes everything
    it.now_ms = 32'd5000;
    send_item(it);
    drop_valid();
    settle();
    write_reg(CFG_MAX_PLEN, 32'd0);
    it.op = OP_TX;
    it.data_len = 8'd1;                              // too big
    send_item(it);
    it.data_len = 8'd0;
    send_item(it);
    drop_valid();
    settle();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      own = (ph == 1) ? 32'hffff_ffff : (ph == 2) ? 32'h0 : node_pool[ph];
      write_reg(CFG_OWN_ID, own);
      write_reg(CFG_IS_GW, (ph % 2 == 0) ? 32'd1 : 32'd0);
      write_reg(CFG_TIMEOUT, (ph == 3) ? 32'hffff_ffff : (ph == 4) ? 32'd1 :
                $urandom_range(500, 6000));
      write_reg(CFG_MAX_HOPS, (ph == 5) ? 32'd255 : (ph == 6) ? 32'd1 :
                $urandom_range(2, 8));
      write_reg(CFG_MAX_PLEN, (ph == 7) ? 32'd255 : $urandom_range(0, 255));
      rsp_stalls = (ph != 3);
      calm = (ph == 7);
      for (int i = 0; i < 230; i++) begin
        it = rand_item(own);
        if (ph == 4 && i == 100) it.op = OP_CLEAN;
        send_item(it);
      end
      drop_valid();
      settle();
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
